FILE: src/cdh_pkg.sv
// shared types and constants for the fft carrier detect holdoff block
package cdh_pkg;

    typedef enum logic [2:0] {
        REG_SIGNAL_BIN_LOW  = 3'd0,
        REG_SIGNAL_BIN_HIGH = 3'd1,
        REG_NOISE_BIN_LOW   = 3'd2,
        REG_NOISE_BIN_HIGH  = 3'd3,
        REG_THRESHOLD_RATIO = 3'd4,
        REG_HOLDOFF_CHUNKS  = 3'd5
    } reg_index_t;

    localparam int BIN_REG_W   = 9;
    localparam int RATIO_W     = 16;
    localparam int HOLDOFF_W   = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 8;

    localparam logic [BIN_REG_W-1:0] SIGNAL_BIN_LOW_RST  = 9'd64;
    localparam logic [BIN_REG_W-1:0] SIGNAL_BIN_HIGH_RST = 9'd160;
    localparam logic [BIN_REG_W-1:0] NOISE_BIN_LOW_RST   = 9'd10;
    localparam logic [BIN_REG_W-1:0] NOISE_BIN_HIGH_RST  = 9'd25;
    localparam logic [RATIO_W-1:0]   THRESHOLD_RATIO_RST = 16'd2560;
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_CHUNKS_RST  = 8'd3;

    typedef struct packed {
        logic [BIN_REG_W-1:0] signal_bin_low;
        logic [BIN_REG_W-1:0] signal_bin_high;
        logic [BIN_REG_W-1:0] noise_bin_low;
        logic [BIN_REG_W-1:0] noise_bin_high;
        logic [RATIO_W-1:0]   threshold_ratio;
        logic [HOLDOFF_W-1:0] holdoff_chunks;
    } cfg_t;

endpackage

FILE: src/fft_carrier_detect_holdoff.sv
// top level: band-energy carrier detector with holdoff
// the result for a chunk is produced by the single multiply-accumulate dft loop,
// which visits every stored sample once per bin for bins 0 to N/2, with N = FFT_POINTS;
// the stored chunk length L is at most N
// throughput: one sample per cycle while a chunk buffer is free; two buffers alternate
// reset: synchronous active-low aresetn clears counters, queue, holdoff state, registers
module fft_carrier_detect_holdoff #(
    parameter int FFT_POINTS  = 512,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cdh_pkg::IN_DATA_W-1:0]      s_tdata,   // sample
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cdh_pkg::OUT_DATA_W-1:0]     m_tdata,   // carrier_active, chunk_present
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cdh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cdh_pkg::CFG_DATA_W-1:0]     cfg_data
);
    localparam int LOG2N = $clog2(FFT_POINTS);
    localparam int JOB_W = LOG2N + 2;

    cdh_pkg::cfg_t    cfg_reg;
    logic             push;
    logic [JOB_W-1:0] push_data;
    logic             full;
    logic             pop;
    logic             head_valid;
    logic [JOB_W-1:0] head_data;
    logic [LOG2N:0]   rd_addr;
    logic signed [SAMPLE_BITS-1:0] rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.signal_bin_low  <= cdh_pkg::SIGNAL_BIN_LOW_RST;
            cfg_reg.signal_bin_high <= cdh_pkg::SIGNAL_BIN_HIGH_RST;
            cfg_reg.noise_bin_low   <= cdh_pkg::NOISE_BIN_LOW_RST;
            cfg_reg.noise_bin_high  <= cdh_pkg::NOISE_BIN_HIGH_RST;
            cfg_reg.threshold_ratio <= cdh_pkg::THRESHOLD_RATIO_RST;
            cfg_reg.holdoff_chunks  <= cdh_pkg::HOLDOFF_CHUNKS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cdh_pkg::REG_SIGNAL_BIN_LOW:
                    cfg_reg.signal_bin_low <= cdh_pkg::BIN_REG_W'(cfg_data);
                cdh_pkg::REG_SIGNAL_BIN_HIGH:
                    cfg_reg.signal_bin_high <= cdh_pkg::BIN_REG_W'(cfg_data);
                cdh_pkg::REG_NOISE_BIN_LOW:
                    cfg_reg.noise_bin_low <= cdh_pkg::BIN_REG_W'(cfg_data);
                cdh_pkg::REG_NOISE_BIN_HIGH:
                    cfg_reg.noise_bin_high <= cdh_pkg::BIN_REG_W'(cfg_data);
                cdh_pkg::REG_THRESHOLD_RATIO:
                    cfg_reg.threshold_ratio <= cdh_pkg::RATIO_W'(cfg_data);
                cdh_pkg::REG_HOLDOFF_CHUNKS:
                    cfg_reg.holdoff_chunks <= cdh_pkg::HOLDOFF_W'(cfg_data);
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    cdh_front #(
        .FFT_POINTS  (FFT_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    cdh_job_fifo #(
        .WIDTH (JOB_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    cdh_back #(
        .FFT_POINTS  (FFT_POINTS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .job_valid (head_valid),
        .job_bank  (head_data[JOB_W-1]),
        .job_count (head_data[JOB_W-2:0]),
        .job_pop   (pop),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: src/cdh_front.sv
// sample capture front end with double-buffered chunk store
module cdh_front #(
    parameter int FFT_POINTS  = 512,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [cdh_pkg::IN_DATA_W-1:0]          s_tdata,
    input  logic                                   s_tlast,
    output logic                                   push,
    output logic [$clog2(FFT_POINTS)+1:0]          push_data,
    input  logic                                   full,
    input  logic [$clog2(FFT_POINTS):0]            rd_addr,
    output logic signed [SAMPLE_BITS-1:0]          rd_data
);
    localparam int LOG2N = $clog2(FFT_POINTS);
    localparam int CNT_W = LOG2N + 1;

    logic [SAMPLE_BITS-1:0] mem [2*FFT_POINTS];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   bank_reg;
    logic                   accept;
    logic                   room;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    assign s_tready   = !full;
    assign accept     = s_tvalid && s_tready;
    assign room       = count_reg < CNT_W'(FFT_POINTS);
    assign count_next = room ? count_reg + CNT_W'(1) : count_reg;
    assign push       = accept && s_tlast;
    assign push_data  = {bank_reg, count_next};
    assign rd_data    = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (accept && room) begin
            mem[{bank_reg, count_reg[LOG2N-1:0]}] <= SAMPLE_BITS'(s_tdata);
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            bank_reg  <= 1'b0;
        end else if (accept) begin
            if (s_tlast) begin
                count_reg <= '0;
                bank_reg  <= !bank_reg;
            end else begin
                count_reg <= count_next;
            end
        end
    end

endmodule

FILE: src/cdh_job_fifo.sv
// two-entry queue of captured chunks waiting for analysis
module cdh_job_fifo #(
    parameter int WIDTH = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);
    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;

    assign full       = fill_reg == 2'd2;
    assign head_valid = fill_reg != 2'd0;
    assign head_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

FILE: src/cdh_back.sv
// per-bin dft engine, band energy sums, threshold compare and holdoff
module cdh_back #(
    parameter int FFT_POINTS  = 512,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  cdh_pkg::cfg_t                         cfg,
    input  logic                                  job_valid,
    input  logic                                  job_bank,
    input  logic [$clog2(FFT_POINTS):0]           job_count,
    output logic                                  job_pop,
    output logic [$clog2(FFT_POINTS):0]           rd_addr,
    input  logic signed [SAMPLE_BITS-1:0]         rd_data,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [cdh_pkg::OUT_DATA_W-1:0]        m_tdata  // carrier_active, chunk_present
);
    localparam int LOG2N  = $clog2(FFT_POINTS);
    localparam int CNT_W  = LOG2N + 1;
    localparam int TW_W   = 17;
    localparam int PROD_W = SAMPLE_BITS + TW_W;
    localparam int ACC_W  = SAMPLE_BITS + LOG2N + 17;
    localparam int NB_W   = LOG2N;
    localparam int CMP_W  = (LOG2N > cdh_pkg::BIN_REG_W) ? LOG2N : cdh_pkg::BIN_REG_W;
    localparam int LN_W   = NB_W + 8;
    localparam int RN_W   = cdh_pkg::RATIO_W + NB_W;
    localparam int PL_W   = 32 + LN_W;
    localparam int PR_W   = 32 + RN_W;
    localparam int WIDE_W = 64 + RN_W + 1;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    typedef logic signed [TW_W-1:0] tw_tab_t [FFT_POINTS];

    function automatic longint unsigned sq_step(input longint unsigned t,
                                                input longint unsigned x);
        return (((t * x) >> 30) * x) >> 30;
    endfunction

    function automatic longint unsigned taylor_q30(input longint unsigned x,
                                                   input logic want_sin);
        longint unsigned term;
        longint          acc;
        if (want_sin) begin
            term = x;
            acc  = longint'(term);
            term = sq_step(term, x) / 64'd6;   acc = acc - longint'(term);
            term = sq_step(term, x) / 64'd20;  acc = acc + longint'(term);
            term = sq_step(term, x) / 64'd42;  acc = acc - longint'(term);
            term = sq_step(term, x) / 64'd72;  acc = acc + longint'(term);
            term = sq_step(term, x) / 64'd110; acc = acc - longint'(term);
            term = sq_step(term, x) / 64'd156; acc = acc + longint'(term);
            term = sq_step(term, x) / 64'd210; acc = acc - longint'(term);
            term = sq_step(term, x) / 64'd272; acc = acc + longint'(term);
        end else begin
            term = ONE_Q30;
            acc  = longint'(term);
            term = sq_step(term, x) / 64'd2;   acc = acc - longint'(term);
            term = sq_step(term, x) / 64'd12;  acc = acc + longint'(term);
            term = sq_step(term, x) / 64'd30;  acc = acc - longint'(term);
            term = sq_step(term, x) / 64'd56;  acc = acc + longint'(term);
            term = sq_step(term, x) / 64'd90;  acc = acc - longint'(term);
            term = sq_step(term, x) / 64'd132; acc = acc + longint'(term);
            term = sq_step(term, x) / 64'd182; acc = acc - longint'(term);
            term = sq_step(term, x) / 64'd240; acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
        return (longint'(acc) + 64'd16384) >> 15;
    endfunction

    function automatic tw_tab_t build_tab(input logic want_cos);
        tw_tab_t         tab;
        longint unsigned q;
        longint unsigned r;
        longint unsigned x;
        longint          s;
        longint          c;
        longint          v;
        for (int m = 0; m < FFT_POINTS; m++) begin
            q = (64'd4 * longint'(m)) / FFT_POINTS;
            r = 64'd4 * longint'(m) - q * FFT_POINTS;
            x = (PI_HALF_Q30 * r) / FFT_POINTS;
            s = longint'(taylor_q30(x, 1'b1));
            c = longint'(taylor_q30(x, 1'b0));
            unique case (q[1:0])
                2'd0:    v = want_cos ? c : s;
                2'd1:    v = want_cos ? -s : c;
                2'd2:    v = want_cos ? -c : -s;
                default: v = want_cos ? s : -c;
            endcase
            tab[m] = TW_W'(v);
        end
        return tab;
    endfunction

    localparam tw_tab_t TW_COS = build_tab(1'b1);
    localparam tw_tab_t TW_SIN = build_tab(1'b0);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RUN, ST_DRAIN, ST_MAG, ST_SQR_RE, ST_SQR_IM, ST_ENERGY,
        ST_BAND, ST_RATIO, ST_MUL_LL, ST_MUL_LH, ST_MUL_RL, ST_MUL_RH, ST_SUM, ST_OUT
    } state_t;

    state_t                     state_reg;
    logic [CNT_W-1:0]           n_reg;
    logic [LOG2N-1:0]           idx_reg;
    logic [LOG2N-1:0]           k_reg;
    logic                       v1_reg;
    logic                       v2_reg;
    logic signed [TW_W-1:0]     cos_reg;
    logic signed [TW_W-1:0]     sin_reg;
    logic signed [PROD_W-1:0]   prod_re_reg;
    logic signed [PROD_W-1:0]   prod_im_reg;
    logic signed [ACC_W-1:0]    re_reg;
    logic signed [ACC_W-1:0]    im_reg;
    logic [63:0]                mag_re_reg;
    logic [63:0]                mag_im_reg;
    logic [63:0]                sq_re_reg;
    logic [63:0]                sq_im_reg;
    logic [63:0]                energy_reg;
    logic [63:0]                sig_sum_reg;
    logic [63:0]                noi_sum_reg;
    logic [NB_W-1:0]            sig_n_reg;
    logic [NB_W-1:0]            noi_n_reg;
    logic [RN_W-1:0]            rn_reg;
    logic [PL_W-1:0]            pll_reg;
    logic [PL_W-1:0]            plh_reg;
    logic [PR_W-1:0]            prl_reg;
    logic [PR_W-1:0]            prh_reg;
    logic [WIDE_W-1:0]          lhs_reg;
    logic [WIDE_W-1:0]          rhs_reg;
    logic                       m_valid_reg;
    logic                       m_active_reg;
    logic                       m_present_reg;
    logic                       active_reg;
    logic [7:0]                 absent_reg;

    logic [ACC_W-1:0]           abs_re;
    logic [ACC_W-1:0]           abs_im;
    logic [64:0]                energy_sum;
    logic [64:0]                sig_add;
    logic [64:0]                noi_add;
    logic [CMP_W-1:0]           k_ext;
    logic                       in_sig;
    logic                       in_noi;
    logic [LN_W-1:0]            ln;
    logic                       out_free;
    logic                       present;
    logic                       active_next;
    logic [7:0]                 absent_next;

    assign rd_addr    = {job_bank, n_reg[LOG2N-1:0]};
    assign abs_re     = re_reg[ACC_W-1] ? ACC_W'(-re_reg) : ACC_W'(re_reg);
    assign abs_im     = im_reg[ACC_W-1] ? ACC_W'(-im_reg) : ACC_W'(im_reg);
    assign energy_sum = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};
    assign sig_add    = {1'b0, sig_sum_reg} + {1'b0, energy_reg};
    assign noi_add    = {1'b0, noi_sum_reg} + {1'b0, energy_reg};
    assign k_ext      = CMP_W'(k_reg);
    assign in_sig     = k_ext >= CMP_W'(cfg.signal_bin_low) && k_ext <= CMP_W'(cfg.signal_bin_high);
    assign in_noi     = k_ext >= CMP_W'(cfg.noise_bin_low) && k_ext <= CMP_W'(cfg.noise_bin_high);
    assign ln         = {noi_n_reg, 8'd0};
    assign out_free   = !m_valid_reg || m_tready;
    assign job_pop    = (state_reg == ST_OUT) && out_free;
    assign present    = (sig_n_reg != '0) && (noi_n_reg != '0) && (noi_sum_reg != 64'd0)
                        && (lhs_reg >= rhs_reg);
    assign absent_next = (absent_reg == 8'd255) ? absent_reg : absent_reg + 8'd1;
    assign active_next = present ? 1'b1
                        : ((absent_next >= cfg.holdoff_chunks) ? 1'b0 : active_reg);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {6'd0, m_present_reg, m_active_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            active_reg  <= 1'b0;
            absent_reg  <= 8'd0;
        end else begin
            if (m_valid_reg && m_tready && !job_pop) begin
                m_valid_reg <= 1'b0;
            end
            cos_reg     <= TW_COS[idx_reg];
            sin_reg     <= TW_SIN[idx_reg];
            v1_reg      <= state_reg == ST_RUN;
            v2_reg      <= v1_reg;
            prod_re_reg <= rd_data * cos_reg;
            prod_im_reg <= rd_data * sin_reg;
            if (v2_reg) begin
                re_reg <= re_reg + ACC_W'(prod_re_reg);
                im_reg <= im_reg - ACC_W'(prod_im_reg);
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        k_reg       <= '0;
                        n_reg       <= '0;
                        idx_reg     <= '0;
                        re_reg      <= '0;
                        im_reg      <= '0;
                        sig_sum_reg <= '0;
                        noi_sum_reg <= '0;
                        sig_n_reg   <= '0;
                        noi_n_reg   <= '0;
                        state_reg   <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    n_reg   <= n_reg + CNT_W'(1);
                    idx_reg <= idx_reg + k_reg;
                    if (n_reg == job_count - CNT_W'(1)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!v1_reg && !v2_reg) begin
                        state_reg <= ST_MAG;
                    end
                end
                ST_MAG: begin
                    mag_re_reg <= 64'((abs_re + ACC_W'(16384)) >> 15);
                    mag_im_reg <= 64'((abs_im + ACC_W'(16384)) >> 15);
                    state_reg  <= ST_SQR_RE;
                end
                ST_SQR_RE: begin
                    sq_re_reg <= (mag_re_reg[63:32] != 32'd0) ? '1
                                 : mag_re_reg[31:0] * mag_re_reg[31:0];
                    state_reg <= ST_SQR_IM;
                end
                ST_SQR_IM: begin
                    sq_im_reg <= (mag_im_reg[63:32] != 32'd0) ? '1
                                 : mag_im_reg[31:0] * mag_im_reg[31:0];
                    state_reg <= ST_ENERGY;
                end
                ST_ENERGY: begin
                    energy_reg <= energy_sum[64] ? '1 : energy_sum[63:0];
                    state_reg  <= ST_BAND;
                end
                ST_BAND: begin
                    if (in_sig) begin
                        sig_sum_reg <= sig_add[64] ? '1 : sig_add[63:0];
                        sig_n_reg   <= sig_n_reg + NB_W'(1);
                    end else if (in_noi) begin
                        noi_sum_reg <= noi_add[64] ? '1 : noi_add[63:0];
                        noi_n_reg   <= noi_n_reg + NB_W'(1);
                    end
                    if (k_reg == LOG2N'(FFT_POINTS / 2)) begin
                        state_reg <= ST_RATIO;
                    end else begin
                        k_reg     <= k_reg + LOG2N'(1);
                        n_reg     <= '0;
                        idx_reg   <= '0;
                        re_reg    <= '0;
                        im_reg    <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RATIO: begin
                    rn_reg    <= cfg.threshold_ratio * sig_n_reg;
                    state_reg <= ST_MUL_LL;
                end
                ST_MUL_LL: begin
                    pll_reg   <= sig_sum_reg[31:0] * ln;
                    state_reg <= ST_MUL_LH;
                end
                ST_MUL_LH: begin
                    plh_reg   <= sig_sum_reg[63:32] * ln;
                    state_reg <= ST_MUL_RL;
                end
                ST_MUL_RL: begin
                    prl_reg   <= noi_sum_reg[31:0] * rn_reg;
                    state_reg <= ST_MUL_RH;
                end
                ST_MUL_RH: begin
                    prh_reg   <= noi_sum_reg[63:32] * rn_reg;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    lhs_reg   <= WIDE_W'(pll_reg) + (WIDE_W'(plh_reg) << 32);
                    rhs_reg   <= WIDE_W'(prl_reg) + (WIDE_W'(prh_reg) << 32);
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        active_reg    <= active_next;
                        absent_reg    <= present ? 8'd0 : absent_next;
                        m_valid_reg   <= 1'b1;
                        m_active_reg  <= active_next;
                        m_present_reg <= present;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_pop_has_job: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> job_valid) else $error("job popped from empty queue");
    a_present_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_present_reg |-> m_active_reg)
        else $error("present chunk without active carrier");
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> n_reg < job_count)
        else $error("sample index past chunk length");
    a_absent_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop && present |=> absent_reg == 8'd0)
        else $error("absent count not cleared on present chunk");
`endif

endmodule
